[rtl/bjs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bjs_pkg
// Shared types and constants for the block jump search engine.
// ----------------------------------------------------------------------------
package bjs_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int KEY_WIDTH   = 32;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = 11;   // entry count, 0..2047 as written
  localparam int STEP_W      = 6;    // floor(sqrt(MAX_ENTRIES)) fits
  localparam int OUT_W       = 11;   // signed result index

  // Result when no index was visited
  localparam logic [OUT_W-1:0] NONE_INDEX = {OUT_W{1'b1}};

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_SCAN
  } srch_state_t;

  // Step unit status handed to the search sequencer
  typedef struct packed {
    logic              busy;
    logic [STEP_W-1:0] step;
    logic [CNT_W-1:0]  count_eff;
  } step_stat_t;

endpackage

[rtl/bjs_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bjs_req_if / bjs_rsp_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface bjs_req_if import bjs_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [ADDR_W-1:0]           entry_index;
  logic signed [KEY_WIDTH-1:0] key_value;

  modport source (output valid, output op, output entry_index, output key_value,
                  input ready);
  modport sink   (input valid, input op, input entry_index, input key_value,
                  output ready);
endinterface

interface bjs_rsp_if import bjs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] found_index;

  modport source (output valid, output found_index, input ready);
  modport sink   (input valid, input found_index, output ready);
endinterface

[rtl/bjs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bjs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bjs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/bjs_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bjs_step
// Entry count register and iterative square root for the jump step.
// ----------------------------------------------------------------------------
module bjs_step import bjs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  output step_stat_t       stat
);

  localparam int BIT_W = $clog2(STEP_W);

  logic                busy;
  logic [STEP_W-1:0]   root;
  logic [CNT_W-1:0]    count_eff;
  logic [BIT_W-1:0]    bit_idx;
  logic [STEP_W-1:0]   trial;
  logic [2*STEP_W-1:0] trial_sq;
  logic [CNT_W-1:0]    cfg_sat;

  // Saturate the written count to the table size
  assign cfg_sat = (cfg_data > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : cfg_data;

  // One result bit per cycle, MSB first
  assign trial    = root | (STEP_W'(1) << bit_idx);
  assign trial_sq = {{STEP_W{1'b0}}, trial} * {{STEP_W{1'b0}}, trial};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      root      <= '0;
      count_eff <= '0;
      bit_idx   <= '0;
    end else if (cfg_we) begin
      busy      <= 1'b1;
      root      <= '0;
      count_eff <= cfg_sat;
      bit_idx   <= BIT_W'(STEP_W - 1);
    end else if (busy) begin
      if (trial_sq <= (2*STEP_W)'(count_eff)) begin
        root <= trial;
      end
      if (bit_idx == '0) begin
        busy <= 1'b0;
      end else begin
        bit_idx <= bit_idx - BIT_W'(1);
      end
    end
  end

  assign stat.busy      = busy;
  assign stat.step      = root;
  assign stat.count_eff = count_eff;

endmodule

[rtl/bjs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bjs_ctrl
// Search sequencer: table writes, probe walk, backward scan, result register.
// ----------------------------------------------------------------------------
module bjs_ctrl import bjs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  bjs_req_if.sink              req,
  bjs_rsp_if.source            rsp,
  input  step_stat_t           stat,
  output logic                 ram_we,
  output logic [ADDR_W-1:0]    ram_waddr,
  output logic [KEY_WIDTH-1:0] ram_wdata,
  output logic [ADDR_W-1:0]    ram_raddr,
  input  logic [KEY_WIDTH-1:0] ram_rdata
);

  srch_state_t                state, state_next;
  logic [CNT_W-1:0]           pos, pos_next;
  logic [CNT_W-1:0]           lo, lo_next;
  logic signed [KEY_WIDTH-1:0] arg;
  logic signed [KEY_WIDTH-1:0] key;
  logic [CNT_W-1:0]           probe_next;
  logic [CNT_W-1:0]           step_ext;
  logic                       accept;
  logic                       load_out;
  logic [OUT_W-1:0]           out_val;
  logic                       out_valid;
  logic [OUT_W-1:0]           out_data;

  // Accept only when idle, the step is settled and the result slot is free
  assign req.ready = (state == S_IDLE) && !stat.busy && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign key      = $signed(ram_rdata);
  assign step_ext = CNT_W'(stat.step);
  assign probe_next = pos + step_ext;

  // Table write port
  assign ram_we    = accept && (req.op == OP_WRITE);
  assign ram_waddr = ADDR_W'(req.entry_index);
  assign ram_wdata = req.key_value;

  // Next state and read address
  always_comb begin
    state_next = state;
    pos_next   = pos;
    lo_next    = lo;
    load_out   = 1'b0;
    out_val    = OUT_W'(pos);
    case (state)
      S_IDLE: begin
        if (accept && (req.op == OP_SEARCH)) begin
          if ((stat.step != '0) && (step_ext < stat.count_eff)) begin
            pos_next   = step_ext;
            state_next = S_PROBE;
          end else begin
            load_out = 1'b1;
            out_val  = NONE_INDEX;
          end
        end
      end
      S_PROBE: begin
        if (key >= arg) begin
          // Key at or above argument: scan back unless done already
          if ((key == arg) || (stat.step == STEP_W'(1))) begin
            load_out   = 1'b1;
            state_next = S_IDLE;
          end else begin
            pos_next   = pos - CNT_W'(1);
            lo_next    = pos - step_ext + CNT_W'(1);
            state_next = S_SCAN;
          end
        end else if (probe_next < stat.count_eff) begin
          pos_next = probe_next;
        end else begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if ((key <= arg) || (pos == lo)) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end else begin
          pos_next = pos - CNT_W'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Read the entry the next cycle works on
  assign ram_raddr = pos_next[ADDR_W-1:0];

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    pos <= pos_next;
    lo  <= lo_next;
    if (accept) begin
      arg <= req.key_value;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      out_data <= out_val;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.found_index = $signed(out_data);

endmodule

[rtl/block_jump_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_jump_search
// Jump search over a table of sorted signed keys held in one RAM.
// ----------------------------------------------------------------------------
// A write beat (op 0) stores key_value at entry_index and gives no result. A
// search beat (op 1) walks the table with step b = floor(sqrt(entry_count)),
// one RAM read per cycle: it probes b, 2b, ... below the count and at the
// first key not below the argument scans back at most b-1 entries; it
// returns the last index visited, or -1. Searches run one at a time; the
// single-port read of the key RAM sets the pace. Writing entry_count starts
// an iterative square root, during which no beat is taken.
// ----------------------------------------------------------------------------
module block_jump_search import bjs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  bjs_req_if.sink          req,
  bjs_rsp_if.source        rsp,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data
);

  step_stat_t           stat;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [KEY_WIDTH-1:0] ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [KEY_WIDTH-1:0] ram_rdata;

  // Count register and step calculation
  bjs_step u_step (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .stat     (stat)
  );

  // Key table
  bjs_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (MAX_ENTRIES)
  ) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Search sequencer
  bjs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .stat      (stat),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule
